// ----- sv/nipd_pkg.sv -----
// ----------------------------------------------------------------------------
// nipd_pkg: shared types and constants of the NEC pulse decoder
// Commands, decoder phases, queue words and register indexes.
// ----------------------------------------------------------------------------
package nipd_pkg;

  localparam int unsigned CodeBits   = 32;
  localparam int unsigned CountW     = 6;
  localparam int unsigned CodeW      = 32;
  localparam int unsigned WidthW     = 16;
  localparam int unsigned NumRegs    = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    CmdEdge    = 2'd0,
    CmdTimeout = 2'd1,
    CmdRearm   = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhLmark  = 3'd1,
    PhLspace = 3'd2,
    PhBmark  = 3'd3,
    PhBspace = 3'd4
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegLeaderMarkMin  = 3'd0,
    RegLeaderMarkMax  = 3'd1,
    RegLeaderSpaceMin = 3'd2,
    RegLeaderSpaceMax = 3'd3,
    RegPulseMin       = 3'd4,
    RegMarkMax        = 3'd5,
    RegSpaceMax       = 3'd6,
    RegOneThreshold   = 3'd7
  } reg_idx_e;

  localparam logic [WidthW-1:0] LeaderMarkMinRst  = 16'd8500;
  localparam logic [WidthW-1:0] LeaderMarkMaxRst  = 16'd9500;
  localparam logic [WidthW-1:0] LeaderSpaceMinRst = 16'd4000;
  localparam logic [WidthW-1:0] LeaderSpaceMaxRst = 16'd5000;
  localparam logic [WidthW-1:0] PulseMinRst       = 16'd400;
  localparam logic [WidthW-1:0] MarkMaxRst        = 16'd700;
  localparam logic [WidthW-1:0] SpaceMaxRst       = 16'd1800;
  localparam logic [WidthW-1:0] OneThresholdRst   = 16'd1000;

  // classified edge word passed from front to back
  typedef struct packed {
    cmd_e kind;
    logic lmark_ok;
    logic lspace_ok;
    logic bmark_ok;
    logic bspace_ok;
    logic bit_one;
  } item_t;

  typedef struct packed {
    logic push;
    logic full;
  } qin_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } qout_t;

endpackage

// ----- sv/nipd_front.sv -----
// ----------------------------------------------------------------------------
// nipd_front: configuration registers and edge classification
// Compares each width against every window so the back needs only the phase.
// ----------------------------------------------------------------------------
module nipd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nipd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [nipd_pkg::WidthW-1:0]  cfg_data_i,
  input  logic [1:0]                   command_i,
  input  logic [nipd_pkg::WidthW-1:0]  elapsed_us_i,
  output nipd_pkg::item_t              item_o
);
  import nipd_pkg::*;

  logic [WidthW-1:0] lm_min_q, lm_max_q, ls_min_q, ls_max_q;
  logic [WidthW-1:0] p_min_q, m_max_q, s_max_q, one_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lm_min_q  <= LeaderMarkMinRst;
      lm_max_q  <= LeaderMarkMaxRst;
      ls_min_q  <= LeaderSpaceMinRst;
      ls_max_q  <= LeaderSpaceMaxRst;
      p_min_q   <= PulseMinRst;
      m_max_q   <= MarkMaxRst;
      s_max_q   <= SpaceMaxRst;
      one_thr_q <= OneThresholdRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegLeaderMarkMin:  lm_min_q  <= cfg_data_i;
        RegLeaderMarkMax:  lm_max_q  <= cfg_data_i;
        RegLeaderSpaceMin: ls_min_q  <= cfg_data_i;
        RegLeaderSpaceMax: ls_max_q  <= cfg_data_i;
        RegPulseMin:       p_min_q   <= cfg_data_i;
        RegMarkMax:        m_max_q   <= cfg_data_i;
        RegSpaceMax:       s_max_q   <= cfg_data_i;
        RegOneThreshold:   one_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic above_pulse;
  assign above_pulse = elapsed_us_i > p_min_q;

  always_comb begin
    item_o.kind      = cmd_e'(command_i);
    item_o.lmark_ok  = (elapsed_us_i > lm_min_q) && (elapsed_us_i < lm_max_q);
    item_o.lspace_ok = (elapsed_us_i > ls_min_q) && (elapsed_us_i < ls_max_q);
    item_o.bmark_ok  = above_pulse && (elapsed_us_i < m_max_q);
    item_o.bspace_ok = above_pulse && (elapsed_us_i < s_max_q);
    item_o.bit_one   = elapsed_us_i >= one_thr_q;
  end

endmodule

// ----- sv/nipd_queue.sv -----
// ----------------------------------------------------------------------------
// nipd_queue: short word queue between front and back
// Register array with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module nipd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nipd_pkg::item_t wdata_i,
  input  logic            pop_i,
  output nipd_pkg::item_t rdata_o,
  output nipd_pkg::qin_t  qin_o,
  output nipd_pkg::qout_t qout_o
);
  import nipd_pkg::*;

  item_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign do_push = push_i && (cnt_q != QCntW'(QueueDepth));
  assign do_pop  = pop_i && (cnt_q != '0);

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    ptr_inc = (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= ptr_inc(wptr_q);
      if (do_pop)  rptr_q <= ptr_inc(rptr_q);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign rdata_o     = mem_q[rptr_q];
  assign qin_o.push  = do_push;
  assign qin_o.full  = cnt_q == QCntW'(QueueDepth);
  assign qout_o.pop  = do_pop;
  assign qout_o.empty = cnt_q == '0;

endmodule

// ----- sv/nipd_back.sv -----
// ----------------------------------------------------------------------------
// nipd_back: frame state machine and result register
// Walks leader and bit phases, shifts in the code, holds the result word.
// ----------------------------------------------------------------------------
module nipd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nipd_pkg::item_t            item_i,
  input  nipd_pkg::qout_t            qout_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 decoder_state_o,
  output logic                       code_done_o,
  output logic [7:0]                 button_o,
  output logic [nipd_pkg::CodeW-1:0] full_code_o,
  output logic                       armed_o
);
  import nipd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [CountW-1:0]  bits_q, bits_d, bits_inc;
  logic [CodeW-1:0]   code_q, code_d, code_shifted;
  logic               arm_q, arm_d;
  logic [7:0]         btn_q, btn_d;
  logic               done_d;
  logic               edge_go, frame_full;

  logic               ovalid_q;
  logic [2:0]         ostate_q;
  logic               odone_q;
  logic [7:0]         obtn_q;
  logic [CodeW-1:0]   ocode_q;
  logic               oarm_q;

  assign pop_o = !qout_i.empty && (!ovalid_q || !out_stall_i);

  assign edge_go      = (item_i.kind == CmdEdge) && arm_q;
  assign bits_inc     = bits_q + 1'b1;
  assign code_shifted = {code_q[CodeW-2:0], item_i.bit_one};
  assign frame_full   = bits_inc >= CountW'(CodeBits);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (item_i.kind == CmdTimeout) begin
      phase_d = PhIdle;
    end else if (edge_go) begin
      unique case (phase_q)
        PhIdle:   phase_d = PhLmark;
        PhLmark:  phase_d = item_i.lmark_ok ? PhLspace : PhIdle;
        PhLspace: phase_d = item_i.lspace_ok ? PhBmark : PhIdle;
        PhBmark:  phase_d = item_i.bmark_ok ? PhBspace : PhIdle;
        PhBspace: phase_d = (item_i.bspace_ok && !frame_full) ? PhBmark : PhIdle;
        default:  phase_d = PhIdle;
      endcase
    end
  end

  // datapath updates
  always_comb begin
    bits_d = bits_q;
    code_d = code_q;
    arm_d  = arm_q;
    btn_d  = btn_q;
    done_d = 1'b0;
    if (item_i.kind == CmdRearm) begin
      arm_d = 1'b1;
    end else if (edge_go) begin
      if (phase_q == PhIdle) begin
        bits_d = '0;
        code_d = '0;
      end else if (phase_q == PhBspace && item_i.bspace_ok) begin
        bits_d = bits_inc;
        code_d = code_shifted;
        if (frame_full) begin
          btn_d  = code_shifted[15:8];
          arm_d  = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      bits_q   <= '0;
      code_q   <= '0;
      arm_q    <= 1'b1;
      btn_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (qout_i.pop) begin
        phase_q  <= phase_d;
        bits_q   <= bits_d;
        code_q   <= code_d;
        arm_q    <= arm_d;
        btn_q    <= btn_d;
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (qout_i.pop) begin
      ostate_q <= phase_d;
      odone_q  <= done_d;
      obtn_q   <= btn_d;
      ocode_q  <= code_d;
      oarm_q   <= arm_d;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign decoder_state_o = ostate_q;
  assign code_done_o     = odone_q;
  assign button_o        = obtn_q;
  assign full_code_o     = ocode_q;
  assign armed_o         = oarm_q;

endmodule

// ----- sv/nec_ir_pulse_decoder.sv -----
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder: NEC infrared frame decoder on edge events
// Classifies edge widths up front, queues them, runs the frame walk behind.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o command_i, elapsed_us_i
//  out      output     out_valid_o/ out_stall_i decoder_state_o, code_done_o,
//                                              button_o, full_code_o, armed_o
//  cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
//  one word per cycle while neither side stalls; a result word becomes valid
//  once its input has passed the queue write and then the state machine step
//  the two-word queue and the result register let both sides stall apart
//  in_stall_o is high only while the queue is full
//  reset restores the window registers to their defaults, idle and armed
module nec_ir_pulse_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nipd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nipd_pkg::WidthW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [nipd_pkg::WidthW-1:0]   elapsed_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    decoder_state_o,
  output logic                          code_done_o,
  output logic [7:0]                    button_o,
  output logic [nipd_pkg::CodeW-1:0]    full_code_o,
  output logic                          armed_o
);
  import nipd_pkg::*;

  item_t fr_item, q_item;
  qin_t  qin;
  qout_t qout;
  logic  pop;

  nipd_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .command_i,
    .elapsed_us_i,
    .item_o (fr_item)
  );

  nipd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (in_valid_i && !qin.full),
    .wdata_i (fr_item),
    .pop_i   (pop),
    .rdata_o (q_item),
    .qin_o   (qin),
    .qout_o  (qout)
  );

  nipd_back u_back (
    .clk_i,
    .rst_ni,
    .item_i (q_item),
    .qout_i (qout),
    .pop_o  (pop),
    .out_valid_o,
    .out_stall_i,
    .decoder_state_o,
    .code_done_o,
    .button_o,
    .full_code_o,
    .armed_o
  );

  assign in_stall_o = qin.full;

  // a finished frame disarms and leaves the walk idle
  a_done_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && code_done_o) |-> (!armed_o && decoder_state_o == PhIdle))
    else $error("frame done without disarm");

  // button is latched from the completed code
  a_done_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && code_done_o) |-> (button_o == full_code_o[15:8]))
    else $error("button does not match code");

  // while disarmed nothing moves the walk out of idle
  a_disarmed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !armed_o) |-> (decoder_state_o == PhIdle))
    else $error("walk active while disarmed");

  // an accepted word always reaches the queue
  a_accept_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> qin.push)
    else $error("accepted word not queued");

endmodule
